// ----- hdl/srl_pkg.sv -----
package srl_pkg;

  localparam int ADDRESS_BITS = 16;
  localparam int CHAR_BITS    = 8;
  localparam int LENGTH_BITS  = 17;
  localparam int REMAIN_BITS  = 9;
  localparam int INDEX_BITS   = 8;
  localparam int HIGH_BITS    = 17;
  localparam int WIDE_BITS    = 19;
  localparam int DIGIT_BITS   = 3;
  localparam int NIBBLE_BITS  = 4;

  localparam logic [CHAR_BITS-1:0] LINE_FEED  = 8'd10;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_SEVEN = 8'h37;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] HEX_A_VALUE  = 8'd10;

  localparam logic [DIGIT_BITS-1:0] COUNT_DIGITS = 3'd2;
  localparam logic [DIGIT_BITS-1:0] ADDR_DIGITS  = 3'd4;
  localparam logic [DIGIT_BITS-1:0] DATA_DIGITS  = 3'd2;
  localparam logic [REMAIN_BITS-1:0] HEADER_BYTES = 9'd3;

  localparam logic [ADDRESS_BITS-1:0] LOW_MARK_RESET = 16'hFFFF;
  localparam logic [LENGTH_BITS-1:0]  LENGTH_MAX     = 17'h10000;

  typedef logic [CHAR_BITS-1:0]    char_t;
  typedef logic [ADDRESS_BITS-1:0] addr_t;
  typedef logic [7:0]              byte_t;
  typedef logic [LENGTH_BITS-1:0]  length_t;

  typedef enum logic {
    KIND_WRITE   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [5:0] {
    PH_LEAD  = 6'b000001,
    PH_TYPE  = 6'b000010,
    PH_COUNT = 6'b000100,
    PH_ADDR  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_SKIP  = 6'b100000
  } phase_t;

  // Letters from 'A' upwards count from ten; anything else is taken from '0'.
  function automatic logic [NIBBLE_BITS-1:0] nibble_of(input char_t c);
    char_t v;
    if (c >= CHAR_UPPER_A) begin
      v = c - CHAR_UPPER_A + HEX_A_VALUE;
    end else begin
      v = c - CHAR_ZERO;
    end
    return v[NIBBLE_BITS-1:0];
  endfunction

endpackage

// ----- hdl/srl_if.sv -----
interface srl_in_if;
  import srl_pkg::*;
  logic  valid;
  logic  ready;
  char_t character;
  logic  end_of_input;
  modport source (output valid, output character, output end_of_input, input ready);
  modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

interface srl_out_if;
  import srl_pkg::*;
  logic    valid;
  logic    ready;
  kind_t   result_kind;
  addr_t   write_address;
  byte_t   byte_data;
  addr_t   lowest_address;
  length_t image_length;
  modport source (output valid, output result_kind, output write_address, output byte_data,
                  output lowest_address, output image_length, input ready);
  modport sink   (input valid, input result_kind, input write_address, input byte_data,
                  input lowest_address, input image_length, output ready);
endinterface

interface srl_cfg_if;
  import srl_pkg::*;
  logic    valid;
  logic    ready;
  length_t length_override;
  modport source (output valid, output length_override, input ready);
  modport sink   (input valid, input length_override, output ready);
endinterface

// ----- hdl/srecord_loader.sv -----
// S-record loader: takes a record stream one character per item and gives a write item for
// every complete data byte and one summary item (low address and image length) when an end
// record or the end of input arrives; after that it swallows items until reset. One item is
// taken every cycle: each character is decoded by a nibble shift and a few compares in the
// same cycle and its result lands in a single output register, so the input only waits
// while that register holds a result that the consumer has not yet taken. The length
// register may be written at any time the block is idle and is always ready.
module srecord_loader (
  input  logic             clk,
  input  logic             rst_n,
  srl_in_if.sink           in_ch,
  srl_out_if.source        out_ch,
  srl_cfg_if.sink          cfg_ch
);
  import srl_pkg::*;

  phase_t                         phase_r, phase_nxt;
  logic [DIGIT_BITS-1:0]          digit_count_r, digit_count_nxt;
  addr_t                          acc_r, acc_nxt;
  addr_t                          record_address_r, record_address_nxt;
  logic signed [REMAIN_BITS-1:0]  remain_r, remain_nxt;
  logic [INDEX_BITS-1:0]          byte_index_r, byte_index_nxt;
  addr_t                          low_mark_r, low_mark_nxt;
  logic [HIGH_BITS-1:0]           high_mark_r, high_mark_nxt;
  logic                           finished_r, finished_nxt;
  length_t                        override_r;

  logic                           out_valid_r;
  kind_t                          out_kind_r, out_kind_nxt;
  addr_t                          out_addr_r, out_addr_nxt;
  byte_t                          out_data_r, out_data_nxt;
  addr_t                          out_low_r, out_low_nxt;
  length_t                        out_len_r, out_len_nxt;

  logic                           in_fire;
  logic                           emit;
  logic                           summary;
  addr_t                          acc_shift;
  logic [DIGIT_BITS-1:0]          digit_inc;
  logic signed [WIDE_BITS-1:0]    top;
  logic signed [WIDE_BITS-1:0]    span;
  length_t                        length_sat;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign acc_shift = {acc_r[ADDRESS_BITS-NIBBLE_BITS-1:0], nibble_of(in_ch.character)};
  assign digit_inc = digit_count_r + 1'b1;

  // Highest address the record reaches; may go negative for short counts.
  assign top = $signed({3'b000, acc_shift})
             + $signed({{(WIDE_BITS-REMAIN_BITS){remain_r[REMAIN_BITS-1]}}, remain_r})
             - $signed(WIDE_BITS'(1));

  always_comb begin
    if (override_r != '0) begin
      span = $signed({2'b00, override_r});
    end else begin
      span = $signed({2'b00, high_mark_r}) - $signed({3'b000, low_mark_r})
           + $signed(WIDE_BITS'(1));
    end
    if (span < 0) begin
      length_sat = '0;
    end else if (span > $signed({2'b00, LENGTH_MAX})) begin
      length_sat = LENGTH_MAX;
    end else begin
      length_sat = span[LENGTH_BITS-1:0];
    end
  end

  always_comb begin
    phase_nxt          = phase_r;
    digit_count_nxt    = digit_count_r;
    acc_nxt            = acc_r;
    record_address_nxt = record_address_r;
    remain_nxt         = remain_r;
    byte_index_nxt     = byte_index_r;
    low_mark_nxt       = low_mark_r;
    high_mark_nxt      = high_mark_r;
    emit               = 1'b0;
    summary            = 1'b0;

    if (finished_r) begin
      emit = 1'b0;
    end else if (in_ch.end_of_input) begin
      summary = 1'b1;
    end else if (in_ch.character == LINE_FEED) begin
      phase_nxt = PH_LEAD;
    end else begin
      case (phase_r)
        PH_LEAD: begin
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          if (in_ch.character >= CHAR_SEVEN) begin
            summary = 1'b1;
          end else begin
            phase_nxt       = PH_COUNT;
            digit_count_nxt = '0;
            acc_nxt         = '0;
          end
        end
        PH_COUNT: begin
          if (digit_inc == COUNT_DIGITS) begin
            remain_nxt      = $signed({1'b0, acc_shift[7:0]}) - $signed(HEADER_BYTES);
            phase_nxt       = PH_ADDR;
            digit_count_nxt = '0;
            acc_nxt         = '0;
          end else begin
            digit_count_nxt = digit_inc;
            acc_nxt         = acc_shift;
          end
        end
        PH_ADDR: begin
          if (digit_inc == ADDR_DIGITS) begin
            record_address_nxt = acc_shift;
            if (acc_shift < low_mark_r) begin
              low_mark_nxt = acc_shift;
            end
            if (top > $signed({2'b00, high_mark_r})) begin
              high_mark_nxt = top[HIGH_BITS-1:0];
            end
            byte_index_nxt  = '0;
            digit_count_nxt = '0;
            acc_nxt         = '0;
            phase_nxt       = (remain_r > 0) ? PH_DATA : PH_SKIP;
          end else begin
            digit_count_nxt = digit_inc;
            acc_nxt         = acc_shift;
          end
        end
        PH_DATA: begin
          if (digit_inc == DATA_DIGITS) begin
            emit            = 1'b1;
            byte_index_nxt  = byte_index_r + 1'b1;
            remain_nxt      = remain_r - $signed(REMAIN_BITS'(1));
            digit_count_nxt = '0;
            acc_nxt         = '0;
            if (remain_r <= $signed(REMAIN_BITS'(1))) begin
              phase_nxt = PH_SKIP;
            end
          end else begin
            digit_count_nxt = digit_inc;
            acc_nxt         = acc_shift;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    finished_nxt = finished_r || summary;

    if (summary) begin
      out_kind_nxt = KIND_SUMMARY;
      out_addr_nxt = '0;
      out_data_nxt = '0;
      out_low_nxt  = low_mark_r;
      out_len_nxt  = length_sat;
    end else begin
      out_kind_nxt = KIND_WRITE;
      out_addr_nxt = record_address_r + {{(ADDRESS_BITS-INDEX_BITS){1'b0}}, byte_index_r};
      out_data_nxt = acc_shift[7:0];
      out_low_nxt  = '0;
      out_len_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_LEAD;
      digit_count_r    <= '0;
      acc_r            <= '0;
      record_address_r <= '0;
      remain_r         <= '0;
      byte_index_r     <= '0;
      low_mark_r       <= LOW_MARK_RESET;
      high_mark_r      <= '0;
      finished_r       <= 1'b0;
      override_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        override_r <= cfg_ch.length_override;
      end
      if (in_fire) begin
        phase_r          <= phase_nxt;
        digit_count_r    <= digit_count_nxt;
        acc_r            <= acc_nxt;
        record_address_r <= record_address_nxt;
        remain_r         <= remain_nxt;
        byte_index_r     <= byte_index_nxt;
        low_mark_r       <= low_mark_nxt;
        high_mark_r      <= high_mark_nxt;
        finished_r       <= finished_nxt;
        out_valid_r      <= emit || summary;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (emit || summary)) begin
      out_kind_r <= out_kind_nxt;
      out_addr_r <= out_addr_nxt;
      out_data_r <= out_data_nxt;
      out_low_r  <= out_low_nxt;
      out_len_r  <= out_len_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_kind_r;
  assign out_ch.write_address  = out_addr_r;
  assign out_ch.byte_data      = out_data_r;
  assign out_ch.lowest_address = out_low_r;
  assign out_ch.image_length   = out_len_r;

`ifndef NO_ASSERTIONS
  // Once the load has finished, no item may produce a further result.
  a_quiet_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && finished_r) |=> !out_valid_r)
    else $error("result produced after the load finished");

  // A summary in the output register implies the finished flag is set.
  a_summary_sets_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_SUMMARY) |-> finished_r)
    else $error("summary shown without finished flag");

  // The data phase is only entered with at least one byte left to decode.
  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (remain_r > 0))
    else $error("data phase with no bytes remaining");
`endif

endmodule
